// ----- src/prmf_pkg.sv -----
// shared types and constants for the push-relabel max flow unit
// no dependencies
`default_nettype none
package prmf_pkg;
  localparam int NODES = 8;
  localparam int CAP_BITS = 16;
  localparam int NB = $clog2(NODES);
  localparam int CELLS = NODES * NODES;
  localparam int CB = $clog2(CELLS);
  localparam int FW = CAP_BITS + 2;
  localparam int EW = CAP_BITS + NB + 2;
  localparam int HW = NB + 3;
  localparam int OUT_W = 19;
  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_SINK = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLR, ST_PRE, ST_PASS, ST_VIS, ST_EDGE, ST_LIFT, ST_SUM, ST_DONE, ST_WIPE
  } state_t;

  typedef struct packed {
    logic clr_node;
    logic pre_edge;
    logic pass_start;
    logic push_edge;
    logic lift_scan;
    logic lift_apply;
    logic sum_edge;
    logic wipe_cell;
    logic src_row;
    logic [NB-1:0] u;
    logic [NB-1:0] v;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic pass_act;
  } stat_t;
endpackage
`default_nettype wire

// ----- src/prmf_datapath.sv -----
// datapath: capacity, flow, excess and height stores, push, lift and sum logic
// depends on prmf_pkg
`default_nettype none
module prmf_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    ld_we,
  input  wire logic [prmf_pkg::NB-1:0] ld_row,
  input  wire logic [prmf_pkg::NB-1:0] ld_col,
  input  wire logic [prmf_pkg::CAP_BITS-1:0] ld_val,
  input  wire logic [prmf_pkg::NB-1:0] src,
  input  wire logic [prmf_pkg::NB-1:0] snk,
  input  wire prmf_pkg::cmd_t          cmd,
  output prmf_pkg::stat_t              stat,
  output logic [prmf_pkg::OUT_W-1:0]   total
);
  import prmf_pkg::*;

  logic [CAP_BITS-1:0] cap_r [CELLS];
  logic signed [FW-1:0] flow_r [CELLS];
  logic signed [EW-1:0] exc_r [NODES];
  logic [HW-1:0] hgt_r [NODES];
  logic [CAP_BITS-1:0] cap_rd_r;
  logic signed [FW-1:0] flow_rd_r;
  logic pass_r, found_r;
  logic [HW-1:0] low_r;
  logic signed [EW+NB:0] sum_r;

  logic [CB-1:0] uv, vu, rd_a;
  logic signed [FW:0] res;
  logic signed [EW-1:0] send;
  logic signed [FW-1:0] fnew;
  logic adm;

  assign uv = {cmd.u, cmd.v};
  assign vu = {cmd.v, cmd.u};
  assign rd_a = cmd.src_row ? {src, cmd.v} : uv;
  assign res = (cmd.u == cmd.v) ? (FW+1)'(0) :
    (FW+1)'($signed({1'b0, cap_rd_r})) - (FW+1)'(flow_rd_r);
  assign adm = (res > 0) && (hgt_r[cmd.u] > hgt_r[cmd.v]);
  assign send = (exc_r[cmd.u] < EW'(res)) ? exc_r[cmd.u] : EW'(res);
  assign fnew = flow_rd_r + FW'(send);

  assign stat.active = (cmd.u != src) && (cmd.u != snk) && (exc_r[cmd.u] > 0);
  assign stat.pass_act = pass_r;
  assign total = (sum_r < 0) ? '0 : OUT_W'(sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (cmd.pass_start) pass_r <= 1'b0;
      if (cmd.clr_node) begin
        found_r <= 1'b0;
        sum_r <= '0;
      end
      if (cmd.push_edge && adm) pass_r <= 1'b1;
      if (cmd.lift_scan && res > 0) begin
        if (!found_r || hgt_r[cmd.v] < low_r) low_r <= hgt_r[cmd.v];
        found_r <= 1'b1;
      end
      if (cmd.lift_apply) begin
        pass_r <= 1'b1;
        found_r <= 1'b0;
      end
      if (cmd.pre_edge) begin
        found_r <= 1'b0;
      end
      if (cmd.sum_edge && cmd.v != src)
        sum_r <= sum_r + (EW+NB+1)'(flow_rd_r);
    end
  end

  always_ff @(posedge clk) begin
    cap_rd_r <= cap_r[rd_a];
    flow_rd_r <= flow_r[rd_a];
    if (ld_we) cap_r[{ld_row, ld_col}] <= ld_val;
    if (cmd.wipe_cell) cap_r[uv] <= '0;
    if (cmd.clr_node) begin
      exc_r[cmd.u] <= '0;
      hgt_r[cmd.u] <= (cmd.u == src) ? HW'(NODES) : '0;
    end
    if (cmd.clr_node || cmd.wipe_cell) begin
      flow_r[uv] <= '0;
      flow_r[vu] <= '0;
    end
    if (cmd.pre_edge && cmd.v != src) begin
      flow_r[{src, cmd.v}] <= FW'(cap_rd_r);
      flow_r[{cmd.v, src}] <= -FW'(cap_rd_r);
      exc_r[cmd.v] <= EW'(cap_rd_r);
    end
    if (cmd.push_edge && adm) begin
      flow_r[uv] <= fnew;
      flow_r[vu] <= -fnew;
      exc_r[cmd.u] <= exc_r[cmd.u] - send;
      exc_r[cmd.v] <= exc_r[cmd.v] + send;
    end
    if (cmd.lift_apply && found_r) hgt_r[cmd.u] <= low_r + 1'b1;
  end
endmodule
`default_nettype wire

// ----- src/prmf_ctrl.sv -----
// controller state machine sequencing clear, preflow, passes, lift, sum and wipe
// depends on prmf_pkg
`default_nettype none
module prmf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           go,
  input  wire prmf_pkg::stat_t stat,
  output prmf_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                done
);
  import prmf_pkg::*;

  state_t st_r, st_nxt;
  logic [CB:0] i_r, i_nxt;
  logic [NB-1:0] u_r, u_nxt;
  logic ph_r, ph_nxt;
  logic [NB-1:0] iu, iv;

  assign iu = i_r[CB-1:NB];
  assign iv = i_r[NB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_WIPE;
      i_r <= '0;
      u_r <= '0;
      ph_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      i_r <= i_nxt;
      u_r <= u_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    i_nxt = i_r;
    u_nxt = u_r;
    ph_nxt = ph_r;
    cmd = '0;
    busy = (st_r != ST_LOAD);
    done = 1'b0;
    case (st_r)
      ST_LOAD: begin
        i_nxt = '0;
        if (go) st_nxt = ST_CLR;
      end
      ST_CLR: begin
        cmd.clr_node = 1'b1;
        cmd.u = iu;
        cmd.v = iv;
        i_nxt = i_r + 1'b1;
        if (i_r == (CB+1)'(CELLS - 1)) begin
          i_nxt = '0;
          st_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.src_row = 1'b1;
        cmd.v = iv;
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          cmd.pre_edge = 1'b1;
          ph_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
          if (iv == NB'(NODES - 1)) st_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        cmd.pass_start = 1'b1;
        u_nxt = '0;
        st_nxt = ST_VIS;
      end
      ST_VIS: begin
        cmd.u = u_r;
        i_nxt = '0;
        if (stat.active) st_nxt = ST_EDGE;
        else if (u_r == NB'(NODES - 1)) st_nxt = stat.pass_act ? ST_PASS : ST_SUM;
        else u_nxt = u_r + 1'b1;
      end
      ST_EDGE: begin
        cmd.u = u_r;
        cmd.v = iv;
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          cmd.push_edge = 1'b1;
          ph_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
          if (iv == NB'(NODES - 1)) begin
            i_nxt = '0;
            st_nxt = ST_LIFT;
          end
        end
      end
      ST_LIFT: begin
        cmd.u = u_r;
        cmd.v = iv;
        if (stat.pass_act) begin
          i_nxt = '0;
          if (u_r == NB'(NODES - 1)) st_nxt = ST_PASS;
          else begin
            u_nxt = u_r + 1'b1;
            st_nxt = ST_VIS;
          end
        end else if (i_r == (CB+1)'(NODES)) begin
          cmd.lift_apply = 1'b1;
          i_nxt = '0;
          if (u_r == NB'(NODES - 1)) st_nxt = ST_PASS;
          else begin
            u_nxt = u_r + 1'b1;
            st_nxt = ST_VIS;
          end
        end else if (!ph_r) ph_nxt = 1'b1;
        else begin
          cmd.lift_scan = 1'b1;
          ph_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
        end
      end
      ST_SUM: begin
        cmd.src_row = 1'b1;
        cmd.v = iv;
        if (!ph_r) ph_nxt = 1'b1;
        else begin
          cmd.sum_edge = 1'b1;
          ph_nxt = 1'b0;
          i_nxt = i_r + 1'b1;
          if (iv == NB'(NODES - 1)) st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        done = 1'b1;
        i_nxt = '0;
        st_nxt = ST_WIPE;
      end
      ST_WIPE: begin
        cmd.wipe_cell = 1'b1;
        cmd.u = iu;
        cmd.v = iv;
        i_nxt = i_r + 1'b1;
        if (i_r == (CB+1)'(CELLS - 1)) st_nxt = ST_LOAD;
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n) done |=> st_r == ST_WIPE)
    else $error("wipe must follow result");
  assert property (@(posedge clk) disable iff (!rst_n) go && !busy |=> busy)
    else $error("start not taken");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.lift_apply |-> !stat.pass_act)
    else $error("lift after activity");
endmodule
`default_nettype wire

// ----- src/push_relabel_max_flow_unit.sv -----
// top level of the push-relabel max flow unit
// depends on prmf_pkg, prmf_ctrl and prmf_datapath
// entries load one per cycle while busy is low; the last one starts clear, preflow,
// passes and sum with busy high, then out_valid is high for a single cycle, then a wipe
// a pass visits each vertex; an active one tries pushes, then relabels if the pass is idle
// sync active-low reset runs a capacity clear with busy high; no output stall
`default_nettype none
module push_relabel_max_flow_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_from_node,
  input  wire logic [2:0]  in_to_node,
  input  wire logic [15:0] in_capacity_value,
  input  wire logic        in_last_entry,
  output logic             out_valid,
  output logic [18:0]      out_total_flow,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data
);
  import prmf_pkg::*;

  logic [NB-1:0] src_r, snk_r;
  cmd_t cmd;
  stat_t stat;
  logic done, acc;
  logic [OUT_W-1:0] total;

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
      snk_r <= NB'(7);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE: src_r <= cfg_data;
        CFG_SINK: snk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  prmf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(acc && in_last_entry), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done)
  );

  prmf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ld_we(acc), .ld_row(in_from_node),
    .ld_col(in_to_node), .ld_val(in_capacity_value), .src(src_r), .snk(snk_r),
    .cmd(cmd), .stat(stat), .total(total)
  );

  assign out_valid = done;
  assign out_total_flow = total;
endmodule
`default_nettype wire
